>>> src/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Register map of the ray versus box slab test unit.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int CSR_IDX_WIDTH = 3;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_HALF_X   = 3'd3,
      CSR_HALF_Y   = 3'd4,
      CSR_HALF_Z   = 3'd5
   } csr_index_type;

endpackage

>>> src/rbst_slab.sv
// ----------------------------------------------------------------------------
// rbst_slab
// One axis of the slab test: bounds, two pipelined saturating dividers for
// the entry and exit parameters, and the near/far selection.
// ----------------------------------------------------------------------------
module rbst_slab #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [COORD_WIDTH-1:0] center,
   input  logic signed [COORD_WIDTH-1:0] half,
   input  logic signed [COORD_WIDTH-1:0] origin,
   input  logic signed [COORD_WIDTH-1:0] dir,
   output logic signed [COORD_WIDTH+1:0] near_t,
   output logic signed [COORD_WIDTH+1:0] far_t,
   output logic                          miss
);

   localparam int W  = COORD_WIDTH;
   localparam int NW = COORD_WIDTH + 2 + FRAC_BITS;
   localparam int TW = NW + COORD_WIDTH;

   // stage 1: bounds
   logic signed [W:0]   lo_ff, hi_ff;
   logic signed [W-1:0] o1_ff, d1_ff;

   // stage 2: numerators and direction flags
   logic signed [W+1:0] num_ff [2];
   logic                dz2_ff, in2_ff, dneg2_ff;
   logic [W-1:0]        dmag2_ff;

   // stage 3: shifted magnitudes
   logic [NW-1:0]       nsh_ff [2];
   logic                qneg3_ff [2];
   logic                dz3_ff, in3_ff, dneg3_ff;
   logic [W-1:0]        dmag3_ff;

   // division steps, entry j feeds step j
   logic [W-1:0]        dmag_ff [W+1];
   logic                dz_ff   [W+1];
   logic                in_ff   [W+1];
   logic                dneg_ff [W+1];

   logic signed [W+1:0] q_t [2];
   logic [W-1:0]        quo [2];
   logic                sat [2];
   logic                qneg [2];

   logic signed [W:0]   oe2;

   assign oe2 = {o1_ff[W-1], o1_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= {center[W-1], center} - {half[W-1], half};
         hi_ff    <= {center[W-1], center} + {half[W-1], half};
         o1_ff    <= origin;
         d1_ff    <= dir;

         num_ff[0] <= {lo_ff[W], lo_ff} - {{2{o1_ff[W-1]}}, o1_ff};
         num_ff[1] <= {hi_ff[W], hi_ff} - {{2{o1_ff[W-1]}}, o1_ff};
         dz2_ff    <= (d1_ff == '0);
         in2_ff    <= !((oe2 < lo_ff) || (hi_ff < oe2));
         dneg2_ff  <= d1_ff[W-1];
         dmag2_ff  <= d1_ff[W-1] ? W'(-d1_ff) : W'(d1_ff);

         dz3_ff    <= dz2_ff;
         in3_ff    <= in2_ff;
         dneg3_ff  <= dneg2_ff;
         dmag3_ff  <= dmag2_ff;

         dz_ff[0]   <= dz3_ff;
         in_ff[0]   <= in3_ff;
         dneg_ff[0] <= dneg3_ff;
         dmag_ff[0] <= dmag3_ff;
      end
   end

   for (genvar s = 0; s < W; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            dz_ff[s+1]   <= dz_ff[s];
            in_ff[s+1]   <= in_ff[s];
            dneg_ff[s+1] <= dneg_ff[s];
            dmag_ff[s+1] <= dmag_ff[s];
         end
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_div
      logic [W-1:0] rem_ff  [W+1];
      logic [W-1:0] low_ff  [W+1];
      logic [W-1:0] quo_ff  [W+1];
      logic         sat_ff  [W+1];
      logic         qneg_ff [W+1];
      logic [W+1:0] mag;
      logic [TW-1:0] nx, dx;
      logic [NW-1:0] top;

      assign mag = num_ff[k][W+1] ? (W+2)'(-num_ff[k]) : (W+2)'(num_ff[k]);
      assign nx  = {{W{1'b0}}, nsh_ff[k]};
      assign dx  = {{(TW-2*W){1'b0}}, dmag3_ff, {W{1'b0}}};
      assign top = nsh_ff[k] >> W;

      always_ff @(posedge clock) begin
         if (en) begin
            nsh_ff[k]   <= {mag, {FRAC_BITS{1'b0}}};
            qneg3_ff[k] <= num_ff[k][W+1] ^ dneg2_ff;
            // quotient of 2^W or more always saturates
            sat_ff[0]   <= (nx >= dx);
            rem_ff[0]   <= top[W-1:0];
            low_ff[0]   <= nsh_ff[k][W-1:0];
            quo_ff[0]   <= '0;
            qneg_ff[0]  <= qneg3_ff[k];
         end
      end

      for (genvar s = 0; s < W; s++) begin : g_step
         logic [W:0] trial, diff;
         logic       ge;
         assign trial = {rem_ff[s], low_ff[s][W-1]};
         assign diff  = trial - {1'b0, dmag_ff[s]};
         assign ge    = (trial >= {1'b0, dmag_ff[s]});
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
               low_ff[s+1]  <= {low_ff[s][W-2:0], 1'b0};
               quo_ff[s+1]  <= {quo_ff[s][W-2:0], ge};
               sat_ff[s+1]  <= sat_ff[s];
               qneg_ff[s+1] <= qneg_ff[s];
            end
         end
      end

      assign quo[k]  = quo_ff[W];
      assign sat[k]  = sat_ff[W];
      assign qneg[k] = qneg_ff[W];
   end

   for (genvar k = 0; k < 2; k++) begin : g_fix
      logic [W-1:0] lim, qs;
      assign lim    = qneg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      assign qs     = (sat[k] || (quo[k] > lim)) ? lim : quo[k];
      assign q_t[k] = qneg[k] ? -$signed({2'b00, qs}) : $signed({2'b00, qs});
   end

   localparam logic signed [W+1:0] T_INF = {2'b01, {W{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         if (dz_ff[W]) begin
            near_t <= -T_INF;
            far_t  <= T_INF;
         end else if (dneg_ff[W]) begin
            near_t <= q_t[1];
            far_t  <= q_t[0];
         end else begin
            near_t <= q_t[0];
            far_t  <= q_t[1];
         end
         miss <= dz_ff[W] && !in_ff[W];
      end
   end

endmodule

>>> src/ray_box_slab_test_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Ray versus axis-aligned box hit test by the slab method.
// ----------------------------------------------------------------------------
// The box is written through the csr_ port (centre and half extent per axis,
// indexes as in rbst_pkg); writes take effect at once. Writes must be made only
// while no ray is in flight; the block itself does not enforce this. Each req_
// beat carries one ray, origin and direction in signed fixed point; each rsp_
// beat carries one hit flag for one ray, in order.
// The three axis dividers are restoring pipelines with one quotient bit per
// stage, plus bound, numerator, scaling, overflow and selection stages and
// two interval stages. A new ray is taken every cycle while the pipeline
// advances.
// The whole pipeline advances when the result register is empty or being
// taken; when the receiver stalls with a result waiting, req_tready drops
// and every stage holds.
// Reset clears the pipeline valid bits and sets the box registers to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int ReqDataWidth = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [ReqDataWidth-1:0]                req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hit
   output logic [7:0]                             rsp_tdata,
   input  logic                                   csr_we,
   input  logic [rbst_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_wdata
);

   import rbst_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int LAT = COORD_WIDTH + 5;

   logic signed [W-1:0] center_ff [3];
   logic signed [W-1:0] half_ff   [3];

   logic                en;
   logic [LAT-1:0]      vld_ff;
   logic                c1_vld_ff;
   logic                rsp_vld_ff;
   logic                hit_ff;

   logic signed [W+1:0] near_t [3];
   logic signed [W+1:0] far_t  [3];
   logic                miss   [3];

   logic signed [W+1:0] tmin_ff, tmax_ff, nz_ff, fz_ff;
   logic                ok1_ff, missz_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, hit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            center_ff[a] <= '0;
            half_ff[a]   <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: center_ff[2] <= csr_wdata;
            CSR_HALF_X:   half_ff[0]   <= csr_wdata;
            CSR_HALF_Y:   half_ff[1]   <= csr_wdata;
            CSR_HALF_Z:   half_ff[2]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbst_slab #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_slab (
         .clock (clock),
         .en    (en),
         .center(center_ff[a]),
         .half  (half_ff[a]),
         .origin($signed(req_tdata[a*W +: W])),
         .dir   ($signed(req_tdata[(a+3)*W +: W])),
         .near_t(near_t[a]),
         .far_t (far_t[a]),
         .miss  (miss[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         c1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[LAT-2:0], req_tvalid};
         c1_vld_ff  <= vld_ff[LAT-1];
         rsp_vld_ff <= c1_vld_ff;
      end
   end

   // x opens the interval, y narrows it
   always_ff @(posedge clock) begin
      if (en) begin
         ok1_ff   <= !miss[0] && !miss[1] &&
                     !((far_t[1] < near_t[0]) || (far_t[0] < near_t[1]));
         tmin_ff  <= (near_t[0] < near_t[1]) ? near_t[1] : near_t[0];
         tmax_ff  <= (far_t[1] < far_t[0]) ? far_t[1] : far_t[0];
         nz_ff    <= near_t[2];
         fz_ff    <= far_t[2];
         missz_ff <= miss[2];
         hit_ff   <= ok1_ff && !missz_ff && !((fz_ff < tmin_ff) || (tmax_ff < nz_ff));
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      en && !c1_vld_ff |=> !rsp_tvalid)
      else $error("result invented from a bubble");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      en && c1_vld_ff |=> rsp_tvalid)
      else $error("result lost in last stage");

endmodule

>>> tb/sv/ray_box_slab_test_unit_tb.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit_tb
// Self-checking bench for the ray versus box slab test unit.
// ----------------------------------------------------------------------------
// Rays are pushed through the req_ stream in bursts while the rsp_ side stalls
// on a pattern of its own. A scoreboard works out the expected hit flag for
// every accepted ray and checks the results in order. The box is rewritten
// between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit_tb;
   import rbst_pkg::*;

   localparam int CW        = 32;
   localparam int FB        = 16;
   localparam int PIPE_LAT  = CW + 7;
   localparam int RAND_RAYS = 1730;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_SPARE = 3'd7;
   localparam logic [CW-1:0] MAX_POS = 32'h7fff_ffff;
   localparam logic [CW-1:0] MAX_NEG = 32'h8000_0000;
   localparam logic [CW-1:0] ONE     = 32'h0001_0000;

   // expected hit flags per ray, with a private copy of the box
   class hit_scoreboard;
      longint box_centre[3];
      longint box_half[3];
      bit     hit_queue[$];

      function longint scaled_quotient(longint num, longint den);
         longint q;
         q = (num <<< FB) / den;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q;
      endfunction

      // false when a flat axis misses; otherwise entry and exit of the slab
      function bit axis_slab(int axis, longint o, longint d,
                             output longint t_near, output longint t_far);
         longint lo, hi, q0, q1;
         lo = box_centre[axis] - box_half[axis];
         hi = box_centre[axis] + box_half[axis];
         t_near = 0;
         t_far  = 0;
         if (d == 0) begin
            if (o < lo || o > hi) return 0;
            t_far  = 64'sd1 <<< 40;
            t_near = -t_far;
            return 1;
         end
         q0 = scaled_quotient(lo - o, d);
         q1 = scaled_quotient(hi - o, d);
         if (d < 0) begin
            t_near = q1;
            t_far  = q0;
         end else begin
            t_near = q0;
            t_far  = q1;
         end
         return 1;
      endfunction

      function void note_ray(logic [6*CW-1:0] ray);
         longint org[3], dir[3], tmin, tmax, n, f;
         bit hit;
         for (int a = 0; a < 3; a++) begin
            org[a] = longint'($signed(ray[a*CW +: CW]));
            dir[a] = longint'($signed(ray[(a+3)*CW +: CW]));
         end
         hit = 0;
         if (axis_slab(0, org[0], dir[0], tmin, tmax) &&
             axis_slab(1, org[1], dir[1], n, f) && !(f < tmin || tmax < n)) begin
            if (tmin < n) tmin = n;
            if (f < tmax) tmax = f;
            if (axis_slab(2, org[2], dir[2], n, f) && !(f < tmin || tmax < n))
               hit = 1;
         end
         hit_queue = {hit_queue, hit};
      endfunction

      function int pending();
         return hit_queue.size();
      endfunction

      // returns 1 when the result matches the oldest expected flag
      function bit check_hit(bit got, output bit want);
         want = hit_queue.pop_front();
         return got == want;
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [6*CW-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [7:0]        rsp_tdata;
   logic              csr_we = 0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CW-1:0]     csr_wdata = '0;

   hit_scoreboard hits = new();
   int  errors = 0;
   int  rays_sent = 0;
   int  hits_seen = 0;
   int  results_seen = 0;
   int  box_settings = 0;
   bit  long_hold_wanted = 0;

   always #1 clock = ~clock;

   ray_box_slab_test_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task automatic report(string what);
      errors++;
      $display("error at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (req_tvalid && req_tready) hits.note_ray(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            hits_seen += rsp_tdata[0];
            if (hits.pending() == 0)
               report("result beat with nothing expected");
            else if (!hits.check_hit(rsp_tdata[0], want))
               report($sformatf("hit is %0b, expected %0b", rsp_tdata[0], want));
         end
      end
   end

   // receiver: changing stall pattern, plus one long hold when asked
   initial begin
      int mode, span;
      forever begin
         if (long_hold_wanted) begin
            long_hold_wanted = 0;
            for (int i = 0; i < 6 * PIPE_LAT; i++) begin
               @(negedge clock);
               rsp_tready = 0;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 120);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1;
               1: rsp_tready = $urandom_range(0, 1);
               2: rsp_tready = ($urandom_range(0, 3) == 0);
               default: rsp_tready = (i % 3 != 2);
            endcase
         end
      end
   end

   task automatic send_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                           logic [CW-1:0] dx, logic [CW-1:0] dy, logic [CW-1:0] dz);
      @(negedge clock);
      req_tvalid = 1;
      req_tdata  = {dz, dy, dx, oz, oy, ox};
      do @(posedge clock); while (!req_tready);
      rays_sent++;
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_tvalid = 0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      pause_sender(0);
      while (hits.pending() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_box(csr_index_type idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = value;
      if (idx <= CSR_HALF_X - 1)
         hits.box_centre[idx] = longint'($signed(value));
      else
         hits.box_half[idx - CSR_HALF_X] = longint'($signed(value));
      @(posedge clock);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_box(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                          logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
      drain();
      write_box(CSR_CENTER_X, cx);
      write_box(CSR_CENTER_Y, cy);
      write_box(CSR_CENTER_Z, cz);
      write_box(CSR_HALF_X, hx);
      write_box(CSR_HALF_Y, hy);
      write_box(CSR_HALF_Z, hz);
      box_settings++;
   endtask

   function automatic logic [CW-1:0] any_coord();
      case ($urandom_range(0, 9))
         0: return MAX_POS;
         1: return MAX_NEG;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
         4, 5: return $signed($urandom_range(0, 2 * 16 * 65536)) - 32'sd1048576;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CW-1:0] near_box(int axis);
      longint span, v;
      span = hits.box_half[axis] < 0 ? -hits.box_half[axis] : hits.box_half[axis];
      span = span * 2 + 65536;
      if (span > 64'sd1073741824) span = 64'sd1073741824;
      v = hits.box_centre[axis] + $signed($urandom_range(0, 2 * span)) - span;
      return v[CW-1:0];
   endfunction

   task automatic random_ray();
      logic [CW-1:0] org[3], dir[3];
      longint aim;
      int shape;
      shape = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         org[a] = (shape < 7) ? near_box(a) : any_coord();
         case (shape)
            // aim roughly at the centre so that many rays hit
            0, 1, 2, 3: begin
               aim = hits.box_centre[a] - longint'($signed(org[a]));
               aim = (aim >>> $urandom_range(0, 12)) + $signed($urandom_range(0, 64)) - 32;
               dir[a] = aim[CW-1:0];
            end
            4: dir[a] = ($urandom_range(0, 2) == 0) ? '0 : any_coord();
            5: dir[a] = $signed($urandom_range(0, 4 * 65536)) - 32'sd131072;
            default: dir[a] = any_coord();
         endcase
      end
      send_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++, count--) random_ray();
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 6));
      end
   endtask

   initial begin
      int per_phase;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset box: a single point at the origin
      send_ray('0, '0, '0, '0, '0, '0);
      send_ray(ONE, '0, '0, '0, '0, '0);
      send_ray(-ONE, '0, '0, ONE, '0, '0);
      send_ray(-ONE, -ONE, '0, ONE, ONE, '0);

      set_box(ONE, -ONE, '0, 2 * ONE, ONE, ONE);
      // flat direction inside and outside the slab
      send_ray(ONE, '0, '0, '0, '0, '0);
      send_ray(4 * ONE, '0, '0, '0, '0, '0);
      // box behind the origin still counts
      send_ray(10 * ONE, -ONE, '0, ONE, '0, '0);
      send_ray(-10 * ONE, -ONE, '0, -ONE, '0, '0);
      // tiny direction: saturated quotients
      send_ray(MAX_NEG, -ONE, '0, 32'h1, '0, '0);
      send_ray(MAX_POS, MAX_NEG, MAX_POS, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
      send_ray(MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_POS, MAX_POS);
      send_ray(MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG, MAX_NEG);
      send_ray(-5 * ONE, -6 * ONE, -5 * ONE, ONE, ONE, ONE);
      send_ray(-5 * ONE, 5 * ONE, '0, ONE, -ONE, '0);

      // negative half extent, and a write to an unused index that must be ignored
      set_box('0, '0, '0, -ONE, ONE, ONE);
      @(negedge clock);
      csr_we = 1;
      csr_index = CSR_IDX_SPARE;
      csr_wdata = MAX_POS;
      @(posedge clock);
      @(negedge clock);
      csr_we = 0;
      send_ray('0, '0, '0, '0, '0, '0);
      send_ray('0, '0, '0, ONE, '0, '0);
      send_ray(-3 * ONE, '0, '0, ONE, '0, '0);

      per_phase = RAND_RAYS / 6;
      random_phase(per_phase);

      // widest bounds in both directions
      set_box(MAX_POS, MAX_NEG, MAX_POS, MAX_POS, MAX_POS, MAX_NEG);
      random_phase(per_phase);

      set_box(MAX_NEG, MAX_POS, '0, MAX_NEG, MAX_NEG, MAX_POS);
      // long receiver hold while the sender keeps offering
      long_hold_wanted = 1;
      random_phase(per_phase);

      set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(per_phase);

      set_box(3 * ONE, -7 * ONE, 32'h0000_8000, 32'h0000_0100, 5 * ONE, '0);
      random_phase(per_phase / 2);
      // wait for every outstanding result before going on
      pause_sender(0);
      while (hits.pending() != 0) @(posedge clock);
      random_phase(per_phase / 2);

      set_box(near_box(0), near_box(1), near_box(2), 20 * ONE, 30 * ONE, 10 * ONE);
      random_phase(RAND_RAYS - 5 * per_phase);

      pause_sender(0);
      while (hits.pending() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (hits.pending() != 0) report("expected results left over");

      $display("rays: %0d sent, %0d results, %0d hits, over %0d box settings",
               rays_sent, results_seen, hits_seen, box_settings);
      $display("covered flat axes, saturated quotients, inverted boxes and long stalls");
      if (errors == 0) begin
         $display("ray_box_slab_test_unit: match");
      end else begin
         $display("ray_box_slab_test_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", hits.pending());
      $display("ray_box_slab_test_unit: mismatch");
      $finish;
   end

endmodule

>>> ray_box_slab_test_unit.f
src/rbst_pkg.sv
src/rbst_slab.sv
src/ray_box_slab_test_unit.sv
tb/sv/ray_box_slab_test_unit_tb.sv
